### sv/prrs_pkg.sv
package prrs_pkg;

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int CNT_W   = 32;
    localparam int TIME_W  = 48;
    localparam int ACPU_W  = 4;
    localparam int SLEN_W  = 16;
    localparam int CFGI_W  = 1;

    localparam logic [1:0] CMD_SUBMIT    = 2'd0;
    localparam logic [1:0] CMD_TERMINATE = 2'd1;
    localparam logic [1:0] CMD_BEGIN     = 2'd2;
    localparam logic [1:0] CMD_END       = 2'd3;

    localparam logic [3:0] K_ACCEPTED    = 4'd0;
    localparam logic [3:0] K_ZERO_ID     = 4'd1;
    localparam logic [3:0] K_FULL        = 4'd2;
    localparam logic [3:0] K_MARKED      = 4'd3;
    localparam logic [3:0] K_IDLE        = 4'd4;
    localparam logic [3:0] K_DISPATCHED  = 4'd5;
    localparam logic [3:0] K_FINISHED    = 4'd6;
    localparam logic [3:0] K_REQUEUED    = 4'd7;
    localparam logic [3:0] K_BUSY        = 4'd8;
    localparam logic [3:0] K_NONE_RUN    = 4'd9;
    localparam logic [3:0] K_UNKNOWN     = 4'd10;

    localparam logic [CFGI_W-1:0] CFG_ACTIVE_CPUS  = 1'd0;
    localparam logic [CFGI_W-1:0] CFG_SLICE_LENGTH = 1'd1;

    typedef struct packed {
        logic [1:0]        command;
        logic [ID_W-1:0]   process_id;
        logic [PRIO_W-1:0] priority_req;
    } t_cmd;

    typedef struct packed {
        logic [3:0]        kind;
        logic [ID_W-1:0]   result_id;
        logic [TIME_W-1:0] run_time;
        logic [TIME_W-1:0] wait_time;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  cycles;
        logic [CNT_W-1:0]  start;
        logic              term;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

### sv/prrs_ram.sv
module prrs_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
    )
    (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/priority_round_robin_scheduler_core.sv
// Results: zero id, full, busy, idle, none running and terminate of id zero answer in the cycle
//   after acceptance; an accepted submit answers likewise and stays busy while it moves entries.
// Terminate: scans every queued and running entry, then answers. Slice begin: one dispatched
// result per moved entry. Slice end: per running entry, a requeued or a finished result.
// Throughput: one command at a time; the next is taken once busy falls.
// Reset: synchronous active low; clears counts and cycle counter, restores config; RAMs kept.
module priority_round_robin_scheduler_core
    import prrs_pkg::*;
    #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_CPUS    = 8
    )
    (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_cmd              i_cmd,
    output logic              o_result_strobe,
    output t_result           o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFGI_W-1:0] i_cfg_index,
    input  logic [SLEN_W-1:0] i_cfg_data
    );

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = AW + 2;
    localparam int RCW = $clog2(MAX_CPUS + 1);
    localparam int RAW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int RD  = (MAX_CPUS > 1) ? MAX_CPUS : 2;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_INS_RD = 12'b000000000010,
        S_INS_WR = 12'b000000000100,
        S_TQ_RD  = 12'b000000001000,
        S_TQ_WR  = 12'b000000010000,
        S_TR_RD  = 12'b000000100000,
        S_TR_WR  = 12'b000001000000,
        S_DQ_RD  = 12'b000010000000,
        S_DQ_WR  = 12'b000100000000,
        S_EN_RD  = 12'b001000000000,
        S_EN_CHK = 12'b010000000000,
        S_EN_MUL = 12'b100000000000
    } t_state;

    t_state              r_state, n_state;
    logic [QCW-1:0]      r_qcount, n_qcount;
    logic [AW-1:0]       r_head, n_head;
    logic [RCW-1:0]      r_rcount, n_rcount;
    logic [CNT_W-1:0]    r_cc, n_cc;
    logic [ACPU_W-1:0]   r_acpu;
    logic [SLEN_W-1:0]   r_slen;
    logic [QCW-1:0]      r_pos, n_pos;
    logic [RCW-1:0]      r_idx, n_idx;
    logic [RCW-1:0]      r_n, n_n;
    logic                r_requeue, n_requeue;
    logic                r_found, n_found;
    t_entry              r_e, n_e;
    t_cmd                r_cmd, n_cmd;
    logic [CNT_W-1:0]    r_run_cyc, n_run_cyc;
    logic [CNT_W-1:0]    r_wait_cyc, n_wait_cyc;
    logic                r_last, n_last;
    t_result             r_out, n_out;
    logic                r_out_vld, n_out_vld;

    logic                q_we;
    logic [AW-1:0]       q_waddr, q_raddr;
    t_entry              q_wdata, q_rdata;
    logic                run_we;
    logic [RAW-1:0]      run_waddr, run_raddr;
    t_entry              run_wdata, run_rdata;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [QCW-1:0] l);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(l);
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    prrs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    prrs_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (run_waddr),
        .i_wdata (run_wdata),
        .i_raddr (run_raddr),
        .o_rdata (run_rdata)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_result_strobe = r_out_vld;
    assign o_result        = r_out;

    always_comb begin
        int unsigned    nc;
        logic [CNT_W-1:0] elapsed;
        logic           lastflag;
        nc         = 0;
        elapsed    = '0;
        lastflag   = 1'b0;
        n_state    = r_state;
        n_qcount   = r_qcount;
        n_head     = r_head;
        n_rcount   = r_rcount;
        n_cc       = r_cc;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_n        = r_n;
        n_requeue  = r_requeue;
        n_found    = r_found;
        n_e        = r_e;
        n_cmd      = r_cmd;
        n_run_cyc  = r_run_cyc;
        n_wait_cyc = r_wait_cyc;
        n_last     = r_last;
        n_out      = r_out;
        n_out_vld  = 1'b0;
        q_we       = 1'b0;
        q_waddr    = '0;
        q_wdata    = r_e;
        q_raddr    = '0;
        run_we     = 1'b0;
        run_waddr  = r_idx[RAW-1:0];
        run_wdata  = run_rdata;
        run_raddr  = r_idx[RAW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd           = i_cmd;
                    n_out           = '0;
                    n_out.last      = 1'b1;
                    n_out.result_id = i_cmd.process_id;
                    case (i_cmd.command)
                        CMD_SUBMIT: begin
                            n_out_vld = 1'b1;
                            if (i_cmd.process_id == '0) begin
                                n_out.kind = K_ZERO_ID;
                            end else if ((SW'(r_qcount) + SW'(r_rcount)) >= SW'(QUEUE_DEPTH)) begin
                                n_out.kind = K_FULL;
                            end else begin
                                n_out.kind = K_ACCEPTED;
                                n_e        = '{id: i_cmd.process_id, prio: i_cmd.priority_req,
                                               cycles: '0, start: r_cc, term: 1'b0};
                                n_pos      = r_qcount;
                                n_requeue  = 1'b0;
                                n_state    = S_INS_RD;
                            end
                        end
                        CMD_TERMINATE: begin
                            if (i_cmd.process_id == '0) begin
                                n_out_vld  = 1'b1;
                                n_out.kind = K_UNKNOWN;
                            end else begin
                                n_found = 1'b0;
                                n_pos   = '0;
                                n_state = S_TQ_RD;
                            end
                        end
                        CMD_BEGIN: begin
                            n_out.result_id = '0;
                            if (r_rcount != '0) begin
                                n_out_vld  = 1'b1;
                                n_out.kind = K_BUSY;
                            end else if (r_qcount == '0) begin
                                n_out_vld  = 1'b1;
                                n_out.kind = K_IDLE;
                            end else begin
                                if (r_cc != '1) begin
                                    n_cc = r_cc + 1'b1;
                                end
                                nc = (r_acpu == '0) ? 1 : 32'(r_acpu);
                                if (nc > MAX_CPUS) begin
                                    nc = MAX_CPUS;
                                end
                                if (nc > 32'(r_qcount)) begin
                                    nc = 32'(r_qcount);
                                end
                                n_n     = RCW'(nc);
                                n_idx   = '0;
                                n_state = S_DQ_RD;
                            end
                        end
                        default: begin
                            n_out.result_id = '0;
                            if (r_rcount == '0) begin
                                n_out_vld  = 1'b1;
                                n_out.kind = K_NONE_RUN;
                            end else begin
                                n_idx   = '0;
                                n_state = S_EN_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    q_we     = 1'b1;
                    q_waddr  = phys(r_head, '0);
                    q_wdata  = r_e;
                    n_qcount = r_qcount + 1'b1;
                    if (r_requeue) begin
                        n_idx = r_idx + 1'b1;
                        if (r_idx + 1'b1 == r_rcount) begin
                            n_rcount = '0;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_EN_RD;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    q_raddr = phys(r_head, r_pos - 1'b1);
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                q_we    = 1'b1;
                q_waddr = phys(r_head, r_pos);
                if (q_rdata.prio < r_e.prio) begin
                    q_wdata = q_rdata;
                    n_pos   = r_pos - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    q_wdata  = r_e;
                    n_qcount = r_qcount + 1'b1;
                    if (r_requeue) begin
                        n_idx = r_idx + 1'b1;
                        if (r_idx + 1'b1 == r_rcount) begin
                            n_rcount = '0;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_EN_RD;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TQ_RD: begin
                if (r_pos == r_qcount) begin
                    n_idx   = '0;
                    n_state = S_TR_RD;
                end else begin
                    q_raddr = phys(r_head, r_pos);
                    n_state = S_TQ_WR;
                end
            end
            S_TQ_WR: begin
                if (q_rdata.id == r_cmd.process_id) begin
                    q_we         = 1'b1;
                    q_waddr      = phys(r_head, r_pos);
                    q_wdata      = q_rdata;
                    q_wdata.term = 1'b1;
                    n_found      = 1'b1;
                end
                n_pos   = r_pos + 1'b1;
                n_state = S_TQ_RD;
            end
            S_TR_RD: begin
                if (r_idx == r_rcount) begin
                    n_out_vld       = 1'b1;
                    n_out           = '0;
                    n_out.kind      = r_found ? K_MARKED : K_UNKNOWN;
                    n_out.result_id = r_cmd.process_id;
                    n_out.last      = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_TR_WR;
                end
            end
            S_TR_WR: begin
                if (run_rdata.id == r_cmd.process_id) begin
                    run_we         = 1'b1;
                    run_wdata      = run_rdata;
                    run_wdata.term = 1'b1;
                    n_found        = 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_TR_RD;
            end
            S_DQ_RD: begin
                q_raddr = r_head;
                n_state = S_DQ_WR;
            end
            S_DQ_WR: begin
                lastflag  = (r_idx + 1'b1 == r_n);
                run_we    = 1'b1;
                run_wdata = q_rdata;
                if (q_rdata.cycles != '1) begin
                    run_wdata.cycles = q_rdata.cycles + 1'b1;
                end
                n_out_vld       = 1'b1;
                n_out           = '0;
                n_out.kind      = K_DISPATCHED;
                n_out.result_id = q_rdata.id;
                n_out.last      = lastflag;
                n_head          = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_qcount        = r_qcount - 1'b1;
                if (lastflag) begin
                    n_rcount = r_n;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DQ_RD;
                end
            end
            S_EN_RD: begin
                n_state = S_EN_CHK;
            end
            S_EN_CHK: begin
                lastflag = (r_idx + 1'b1 == r_rcount);
                n_last   = lastflag;
                n_e      = run_rdata;
                if (run_rdata.term) begin
                    elapsed    = (r_cc >= run_rdata.start) ? r_cc - run_rdata.start : '0;
                    n_run_cyc  = run_rdata.cycles;
                    n_wait_cyc = (elapsed >= run_rdata.cycles) ? elapsed - run_rdata.cycles : '0;
                    n_state    = S_EN_MUL;
                end else begin
                    n_out_vld       = 1'b1;
                    n_out           = '0;
                    n_out.kind      = K_REQUEUED;
                    n_out.result_id = run_rdata.id;
                    n_out.last      = lastflag;
                    n_pos           = r_qcount;
                    n_requeue       = 1'b1;
                    n_state         = S_INS_RD;
                end
            end
            S_EN_MUL: begin
                n_out_vld       = 1'b1;
                n_out.kind      = K_FINISHED;
                n_out.result_id = r_e.id;
                n_out.run_time  = TIME_W'(r_run_cyc * r_slen);
                n_out.wait_time = TIME_W'(r_wait_cyc * r_slen);
                n_out.last      = r_last;
                n_idx           = r_idx + 1'b1;
                if (r_last) begin
                    n_rcount = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_EN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_qcount  <= '0;
            r_head    <= '0;
            r_rcount  <= '0;
            r_cc      <= '0;
            r_acpu    <= ACPU_W'(1);
            r_slen    <= SLEN_W'(1);
            r_out_vld <= 1'b0;
            r_requeue <= 1'b0;
            r_found   <= 1'b0;
            r_pos     <= '0;
            r_idx     <= '0;
            r_n       <= '0;
        end else begin
            r_state   <= n_state;
            r_qcount  <= n_qcount;
            r_head    <= n_head;
            r_rcount  <= n_rcount;
            r_cc      <= n_cc;
            r_out_vld <= n_out_vld;
            r_requeue <= n_requeue;
            r_found   <= n_found;
            r_pos     <= n_pos;
            r_idx     <= n_idx;
            r_n       <= n_n;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ACTIVE_CPUS:  r_acpu <= i_cfg_data[ACPU_W-1:0];
                    CFG_SLICE_LENGTH: r_slen <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e        <= n_e;
        r_cmd      <= n_cmd;
        r_run_cyc  <= n_run_cyc;
        r_wait_cyc <= n_wait_cyc;
        r_last     <= n_last;
        r_out      <= n_out;
    end

endmodule

### sv/prrs_checker.sv
module prrs_checker
    import prrs_pkg::*;
    (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    busy,
    input  logic    o_result_strobe,
    input  t_result o_result,
    input  logic    o_cfg_ready
    );

    a_idle_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy after reset");

    a_no_result_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_result_strobe)
        else $error("result after reset");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_result_strobe)
        else $error("accepted transaction made no progress");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_result.last |-> busy)
        else $error("idle before last result");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("config port stalled");

endmodule

bind priority_round_robin_scheduler_core prrs_checker u_prrs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_result        (o_result),
    .o_cfg_ready     (o_cfg_ready)
);
